### design/pedestal_channel_accumulator_unit_defines.svh
// Assertion macros for the pedestal channel accumulator checker.
// Needs nothing else; included by the files that assert.
`ifndef PEDESTAL_CHANNEL_ACCUMULATOR_UNIT_DEFINES_SVH
`define PEDESTAL_CHANNEL_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PCA_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pedestal accumulator assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define PCA_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pedestal accumulator assertion failed");

`endif

### design/pca_pkg.sv
// Shared widths, codes, table entry type and width helpers of the pedestal accumulator.
// Depends on nothing; used by the front part, the back part, the top level and the checker.
package pca_pkg;

	localparam int CHAN_W = 10;
	localparam int ADC_W = 10;
	localparam int TOT_W = 12;
	localparam int TOA_W = 10;
	localparam int SUM_W = 42;
	localparam int SQ_W = 52;
	localparam int CNT_W = 32;
	localparam int FLAG_N = 4;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 264;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam int CHANNELS_DEF = 1024;
	localparam int MAX_SAMPLES_DEF = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_DATA_W-1:0] LOW_CUTOFF_RST = 11'd10;
	localparam logic [CFG_DATA_W-1:0] HIGH_CUTOFF_RST = 11'd512;

	localparam logic [CFG_IDX_W-1:0] CFG_TOT_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOA_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUT = 2'd3;

	localparam int FLAG_TOT = 0;
	localparam int FLAG_TOA = 1;
	localparam int FLAG_UNDER = 2;
	localparam int FLAG_OVER = 3;

	localparam int ADC_MAX = (1 << ADC_W) - 1;

	typedef struct packed {
		logic [FLAG_N-1:0][CNT_W-1:0] rej;
		logic [CNT_W-1:0] entries;
		logic [SQ_W-1:0] sq;
		logic [SUM_W-1:0] sum;
	} entry_t;

	function automatic int dsum_width(int max_samples);
		return $clog2(max_samples * ADC_MAX + 1);
	endfunction

	function automatic int dsq_width(int max_samples);
		return $clog2(max_samples * ADC_MAX * ADC_MAX + 1);
	endfunction

	function automatic int dcnt_width(int max_samples);
		return $clog2(max_samples + 1);
	endfunction

	function automatic int rec_width(int max_samples);
		return CHAN_W + dsum_width(max_samples) + dsq_width(max_samples)
			+ dcnt_width(max_samples) + FLAG_N;
	endfunction

endpackage

### design/pca_front.sv
// Front part: configuration registers, sample intake and per-digi accumulation.
// Depends on pca_pkg; pushes one commit record per closed digi of an in-range channel into the queue.
module pca_front #(
	parameter int CHANNELS = pca_pkg::CHANNELS_DEF,
	parameter int MAX_SAMPLES = pca_pkg::MAX_SAMPLES_DEF,
	localparam int REC_W = pca_pkg::rec_width(MAX_SAMPLES)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [pca_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic s_tlast,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pca_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic queue_full,
	input  logic clearing,
	output logic push,
	output logic [REC_W-1:0] push_data
);

	localparam int DS_W = pca_pkg::dsum_width(MAX_SAMPLES);
	localparam int DQ_W = pca_pkg::dsq_width(MAX_SAMPLES);
	localparam int DC_W = pca_pkg::dcnt_width(MAX_SAMPLES);

	logic tot_en_q;
	logic toa_en_q;
	logic [pca_pkg::CFG_DATA_W-1:0] low_cut_q;
	logic [pca_pkg::CFG_DATA_W-1:0] high_cut_q;

	logic [DS_W-1:0] dsum_q;
	logic [DQ_W-1:0] dsq_q;
	logic [DC_W-1:0] dcnt_q;
	logic [pca_pkg::FLAG_N-1:0] flags_q;

	logic [pca_pkg::CHAN_W-1:0] channel;
	logic [pca_pkg::ADC_W-1:0] adc_value;
	logic [pca_pkg::TOT_W-1:0] tot_value;
	logic [pca_pkg::TOA_W-1:0] toa_value;

	logic accept;
	logic take;
	logic in_range;
	logic [2*pca_pkg::ADC_W-1:0] adc_sq;
	logic [DS_W-1:0] dsum_d;
	logic [DQ_W-1:0] dsq_d;
	logic [DC_W-1:0] dcnt_d;
	logic [pca_pkg::FLAG_N-1:0] flags_d;

	assign channel = s_tdata[9:0];
	assign adc_value = s_tdata[19:10];
	assign tot_value = s_tdata[31:20];
	assign toa_value = s_tdata[41:32];

	assign s_tready = !queue_full && !clearing;
	assign accept = s_tvalid && s_tready;
	assign in_range = 32'(channel) < CHANNELS;

	always_comb begin
		flags_d = flags_q;
		if (tot_en_q && (tot_value != '0)) flags_d[pca_pkg::FLAG_TOT] = 1'b1;
		if (toa_en_q && (toa_value != '0)) flags_d[pca_pkg::FLAG_TOA] = 1'b1;
		if ({1'b0, adc_value} < low_cut_q) flags_d[pca_pkg::FLAG_UNDER] = 1'b1;
		if ({1'b0, adc_value} > high_cut_q) flags_d[pca_pkg::FLAG_OVER] = 1'b1;
		take = dcnt_q < DC_W'(MAX_SAMPLES);
		adc_sq = adc_value * adc_value;
		dsum_d = dsum_q;
		dsq_d = dsq_q;
		dcnt_d = dcnt_q;
		if (take) begin
			dsum_d = dsum_q + DS_W'(adc_value);
			dsq_d = dsq_q + DQ_W'(adc_sq);
			dcnt_d = dcnt_q + DC_W'(1);
		end
	end

	assign push = accept && s_tlast && in_range;
	assign push_data = {flags_d, dcnt_d, dsq_d, dsum_d, channel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_en_q <= 1'b1;
			toa_en_q <= 1'b1;
			low_cut_q <= pca_pkg::LOW_CUTOFF_RST;
			high_cut_q <= pca_pkg::HIGH_CUTOFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pca_pkg::CFG_TOT_EN: tot_en_q <= cfg_data[0];
				pca_pkg::CFG_TOA_EN: toa_en_q <= cfg_data[0];
				pca_pkg::CFG_LOW_CUT: low_cut_q <= cfg_data;
				pca_pkg::CFG_HIGH_CUT: high_cut_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsum_q <= '0;
			dsq_q <= '0;
			dcnt_q <= '0;
			flags_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				dsum_q <= '0;
				dsq_q <= '0;
				dcnt_q <= '0;
				flags_q <= '0;
			end else begin
				dsum_q <= dsum_d;
				dsq_q <= dsq_d;
				dcnt_q <= dcnt_d;
				flags_q <= flags_d;
			end
		end
	end

endmodule

### design/pca_queue.sv
// Short first-in first-out queue of commit records between the front and back parts.
// Depends on nothing; width and depth come from the instantiating module.
module pca_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	input  logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [FW-1:0] fill_q;

	assign full = fill_q == FW'(DEPTH);
	assign empty = fill_q == '0;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			if (push && !pop) fill_q <= FW'(fill_q + 1'b1);
			else if (pop && !push) fill_q <= FW'(fill_q - 1'b1);
		end
	end

endmodule

### design/pca_back.sv
// Back part: channel table memory, clearing pass, read-modify-write commit and result register.
// Depends on pca_pkg; takes commit records from the queue.
module pca_back #(
	parameter int CHANNELS = pca_pkg::CHANNELS_DEF,
	parameter int MAX_SAMPLES = pca_pkg::MAX_SAMPLES_DEF,
	localparam int REC_W = pca_pkg::rec_width(MAX_SAMPLES)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [REC_W-1:0] q_data,
	input  logic q_empty,
	output logic q_pop,
	output logic clearing,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [pca_pkg::M_TDATA_W-1:0] m_tdata,
	output logic m_tuser
);

	localparam int DS_W = pca_pkg::dsum_width(MAX_SAMPLES);
	localparam int DQ_W = pca_pkg::dsq_width(MAX_SAMPLES);
	localparam int DC_W = pca_pkg::dcnt_width(MAX_SAMPLES);
	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_W = pca_pkg::SUM_W;
	localparam int SQ_W = pca_pkg::SQ_W;
	localparam int CNT_W = pca_pkg::CNT_W;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_UPDATE} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [REC_W-1:0] cmt_q;
	logic m_tvalid_q;
	logic [pca_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic m_tuser_q;

	pca_pkg::entry_t mem [CHANNELS];
	pca_pkg::entry_t rd_q;

	logic [pca_pkg::CHAN_W-1:0] c_chan;
	logic [DS_W-1:0] c_sum;
	logic [DQ_W-1:0] c_sq;
	logic [DC_W-1:0] c_cnt;
	logic [pca_pkg::FLAG_N-1:0] c_flags;
	logic ok;
	logic out_free;
	logic [SUM_W:0] sum_ext;
	logic [SQ_W:0] sq_ext;
	logic [CNT_W:0] cnt_ext;
	logic [CNT_W:0] rej_ext [pca_pkg::FLAG_N];
	pca_pkg::entry_t upd;

	logic mem_we;
	logic mem_re;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	pca_pkg::entry_t mem_wdata;

	assign {c_flags, c_cnt, c_sq, c_sum, c_chan} = cmt_q;
	assign ok = c_flags == '0;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		sum_ext = {1'b0, rd_q.sum} + (SUM_W + 1)'(c_sum);
		sq_ext = {1'b0, rd_q.sq} + (SQ_W + 1)'(c_sq);
		cnt_ext = {1'b0, rd_q.entries} + (CNT_W + 1)'(c_cnt);
		upd = rd_q;
		if (ok) begin
			upd.sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			upd.sq = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
			upd.entries = cnt_ext[CNT_W] ? '1 : cnt_ext[CNT_W-1:0];
		end
		for (int k = 0; k < pca_pkg::FLAG_N; k++) begin
			rej_ext[k] = {1'b0, rd_q.rej[k]} + (CNT_W + 1)'(1);
			if (c_flags[k]) upd.rej[k] = rej_ext[k][CNT_W] ? '1 : rej_ext[k][CNT_W-1:0];
		end
	end

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign mem_re = q_pop;
	assign mem_raddr = AW'(q_data[pca_pkg::CHAN_W-1:0]);
	assign mem_we = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && out_free);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(c_chan);
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : upd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cmt_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
		end else begin
			if ((state_q == ST_UPDATE) && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(CHANNELS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (!q_empty) begin
						cmt_q <= q_data;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						m_tdata_q <= {upd.rej[pca_pkg::FLAG_OVER], upd.rej[pca_pkg::FLAG_UNDER],
							upd.rej[pca_pkg::FLAG_TOA], upd.rej[pca_pkg::FLAG_TOT],
							upd.entries, upd.sq, upd.sum, c_chan};
						m_tuser_q <= ok;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign clearing = state_q == ST_CLEAR;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

### design/pedestal_channel_accumulator_unit.sv
// Pedestal channel accumulator, top level: front part, commit queue and back part.
// Samples are taken one per cycle unless the queue is full or a clearing pass runs; a digi's
// result passes through the queue, the commit register and the result register. The back
// part commits one digi at a time; a four-entry queue absorbs bursts of short digis. After
// reset a clearing pass zeroes the whole table, while samples wait and configuration is accepted.
// Depends on pca_pkg, pca_front, pca_queue and pca_back.
module pedestal_channel_accumulator_unit #(
	parameter int CHANNELS = pca_pkg::CHANNELS_DEF,
	parameter int MAX_SAMPLES = pca_pkg::MAX_SAMPLES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// channel[9:0], adc_value[19:10], tot_value[31:20], toa_value[41:32], zero[47:42]
	input  logic [pca_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// out_channel[9:0], sum_adc[51:10], sum_adc_squared[103:52], entry_count[135:104],
	// tot_rejects[167:136], toa_rejects[199:168], under_rejects[231:200], over_rejects[263:232]
	output logic [pca_pkg::M_TDATA_W-1:0] m_tdata,
	// accepted[0]
	output logic m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pca_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int REC_W = pca_pkg::rec_width(MAX_SAMPLES);

	logic push;
	logic [REC_W-1:0] push_data;
	logic pop;
	logic [REC_W-1:0] pop_data;
	logic q_full;
	logic q_empty;
	logic clearing;

	assign cfg_ready = 1'b1;

	pca_front #(
		.CHANNELS(CHANNELS),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.queue_full(q_full),
		.clearing(clearing),
		.push(push),
		.push_data(push_data)
	);

	pca_queue #(
		.WIDTH(REC_W),
		.DEPTH(pca_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.full(q_full),
		.empty(q_empty)
	);

	pca_back #(
		.CHANNELS(CHANNELS),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_data(pop_data),
		.q_empty(q_empty),
		.q_pop(pop),
		.clearing(clearing),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

endmodule

### design/pca_checker.sv
// Port-level checker for the pedestal channel accumulator, bound to the top level.
// Depends on pca_pkg and the assertion macros header.
`include "pedestal_channel_accumulator_unit_defines.svh"

module pca_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [pca_pkg::M_TDATA_W-1:0] m_tdata,
	input logic m_tuser
);

	// A stalled result word keeps its contents.
	`PCA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// An accumulated digi always leaves the channel with a nonzero sample count.
	`PCA_ASSERT_IMPL(a_accept_count, clk, arst_n, m_tvalid && m_tuser, m_tdata[135:104] != '0)

	// A rejected digi always leaves at least one reject counter nonzero.
	`PCA_ASSERT_IMPL(a_reject_count, clk, arst_n, m_tvalid && !m_tuser, m_tdata[263:136] != '0)

endmodule

bind pedestal_channel_accumulator_unit pca_checker u_pca_checker (.*);
